// ===== rtl/bfsp_pkg.sv =====
// shared types and constants for the shortest path unit
// no dependencies
package bfsp_pkg;

    localparam int VTX_BITS  = 6;
    localparam int DIST_BITS = 32;
    localparam logic signed [DIST_BITS-1:0] DIST_INF = 32'sd536870912;

    typedef struct packed {
        logic load_edge;
        logic clear_set;
        logic init_run;
        logic edge_rd;
        logic dist_rd;
        logic relax;
        logic clear_changed;
        logic eidx_clr;
        logic eidx_inc;
        logic pass_clr;
        logic pass_inc;
        logic vidx_clr;
        logic vidx_inc;
        logic out_rd;
        logic out_load_vtx;
        logic out_load_neg;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic edge_end;
        logic pass_end;
        logic changed;
        logic out_last;
    } t_sts;

endpackage

// ===== rtl/bfsp_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module bfsp_ram #(
    parameter int W  = 8,
    parameter int D  = 16,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/bfsp_ctrl.sv =====
// controller state machine: edge loading, relaxation passes, result output
// depends on bfsp_pkg
module bfsp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_edge_last,
    input  logic          i_ready,
    output logic          o_ready,
    output logic          o_valid,
    input  bfsp_pkg::t_sts i_sts,
    output bfsp_pkg::t_cmd o_cmd
);
    import bfsp_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_INIT  = 4'd2;
    localparam logic [3:0] S_EDGE  = 4'd3;
    localparam logic [3:0] S_DIST  = 4'd4;
    localparam logic [3:0] S_RELAX = 4'd5;
    localparam logic [3:0] S_PASS  = 4'd6;
    localparam logic [3:0] S_ORD   = 4'd7;
    localparam logic [3:0] S_OLOAD = 4'd8;
    localparam logic [3:0] S_NEG   = 4'd9;
    localparam logic [3:0] S_OWAIT = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_cmd       cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                cmd.load_edge = i_valid;
                if (i_valid && i_edge_last) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = i_sts.empty ? S_DONE : S_INIT;
            end
            S_INIT: begin
                cmd.init_run      = 1'b1;
                cmd.eidx_clr      = 1'b1;
                cmd.pass_clr      = 1'b1;
                cmd.clear_changed = 1'b1;
                n_state           = S_EDGE;
            end
            S_EDGE: begin
                cmd.edge_rd = 1'b1;
                n_state     = S_DIST;
            end
            S_DIST: begin
                cmd.dist_rd = 1'b1;
                n_state     = S_RELAX;
            end
            S_RELAX: begin
                cmd.relax = 1'b1;
                if (i_sts.edge_end) begin
                    n_state = S_PASS;
                end else begin
                    cmd.eidx_inc = 1'b1;
                    n_state      = S_EDGE;
                end
            end
            S_PASS: begin
                priority if (!i_sts.changed) begin
                    cmd.vidx_clr = 1'b1;
                    n_state      = S_ORD;
                end else if (i_sts.pass_end) begin
                    n_state = S_NEG;
                end else begin
                    cmd.pass_inc      = 1'b1;
                    cmd.eidx_clr      = 1'b1;
                    cmd.clear_changed = 1'b1;
                    n_state           = S_EDGE;
                end
            end
            S_ORD: begin
                cmd.out_rd = 1'b1;
                n_state    = S_OLOAD;
            end
            S_OLOAD: begin
                cmd.out_load_vtx = 1'b1;
                n_state          = S_OWAIT;
            end
            S_NEG: begin
                cmd.out_load_neg = 1'b1;
                n_state          = S_OWAIT;
            end
            S_OWAIT: begin
                if (i_ready) begin
                    if (i_sts.out_last) begin
                        n_state = S_DONE;
                    end else begin
                        cmd.vidx_inc = 1'b1;
                        n_state      = S_ORD;
                    end
                end
            end
            S_DONE: begin
                cmd.clear_set = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd   = cmd;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OWAIT);
endmodule

// ===== rtl/bfsp_dpath.sv =====
// datapath: edge store, distance tables, reach flags, counters, result word
// depends on bfsp_pkg and bfsp_ram
module bfsp_dpath #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [bfsp_pkg::VTX_BITS-1:0]      i_cfg_data,
    input  logic [bfsp_pkg::VTX_BITS-1:0]      i_edge_from,
    input  logic [bfsp_pkg::VTX_BITS-1:0]      i_edge_to,
    input  logic signed [WEIGHT_BITS-1:0]      i_edge_weight,
    input  bfsp_pkg::t_cmd                     i_cmd,
    output bfsp_pkg::t_sts                     o_sts,
    output logic [bfsp_pkg::VTX_BITS-1:0]      o_vertex_index,
    output logic signed [bfsp_pkg::DIST_BITS-1:0] o_distance,
    output logic                               o_reachable,
    output logic                               o_negative_cycle,
    output logic                               o_result_last
);
    import bfsp_pkg::*;

    localparam int VW     = $clog2(MAX_VERTICES);
    localparam int VCW    = $clog2(MAX_VERTICES + 1);
    localparam int EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW    = $clog2(MAX_EDGES + 1);
    localparam int EW     = 2 * VW + WEIGHT_BITS;
    localparam int DW_RAW = WEIGHT_BITS + EAW + VW + 2;
    localparam int DW     = (DW_RAW > DIST_BITS) ? DW_RAW : DIST_BITS;

    logic [VTX_BITS-1:0]     r_src;
    logic [ECW-1:0]          r_edge_count;
    logic [VCW-1:0]          r_vtx_count;
    logic [ECW-1:0]          r_eidx;
    logic [VCW-1:0]          r_pass;
    logic                    r_changed;
    logic [VW-1:0]           r_vidx;
    logic [MAX_VERTICES-1:0] r_reached;
    logic [VTX_BITS-1:0]     r_o_vertex;
    logic signed [DIST_BITS-1:0] r_o_dist;
    logic                    r_o_reach;
    logic                    r_o_neg;
    logic                    r_o_last;

    logic                    store_ok;
    logic [VTX_BITS:0]       from_p1;
    logic [VTX_BITS:0]       to_p1;
    logic [VTX_BITS:0]       vc_ext;
    logic [VTX_BITS:0]       n_vc_ext;
    logic [EW-1:0]           edge_wdata;
    logic [EW-1:0]           edge_q;
    logic [VW-1:0]           ea;
    logic [VW-1:0]           eb;
    logic signed [WEIGHT_BITS-1:0] ew;
    logic signed [DW-1:0]    da;
    logic signed [DW-1:0]    db;
    logic signed [DW-1:0]    cand;
    logic                    upd;
    logic                    src_ok;
    logic [VW-1:0]           src_addr;
    logic                    dist_we;
    logic [VW-1:0]           dist_waddr;
    logic signed [DW-1:0]    dist_wdata;
    logic [VW-1:0]           a_raddr;
    logic                    vidx_last;

    assign from_p1  = {1'b0, i_edge_from} + (VTX_BITS+1)'(1);
    assign to_p1    = {1'b0, i_edge_to} + (VTX_BITS+1)'(1);
    assign vc_ext   = (VTX_BITS+1)'(r_vtx_count);
    assign store_ok = (r_edge_count < ECW'(MAX_EDGES))
                   && ({1'b0, i_edge_from} < (VTX_BITS+1)'(MAX_VERTICES))
                   && ({1'b0, i_edge_to} < (VTX_BITS+1)'(MAX_VERTICES));

    always_comb begin
        n_vc_ext = vc_ext;
        if (from_p1 > n_vc_ext) begin
            n_vc_ext = from_p1;
        end
        if (to_p1 > n_vc_ext) begin
            n_vc_ext = to_p1;
        end
    end

    assign edge_wdata = {i_edge_from[VW-1:0], i_edge_to[VW-1:0], i_edge_weight};

    bfsp_ram #(.W(EW), .D(MAX_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_edge && store_ok),
        .i_waddr (r_edge_count[EAW-1:0]),
        .i_wdata (edge_wdata),
        .i_re    (i_cmd.edge_rd),
        .i_raddr (r_eidx[EAW-1:0]),
        .o_rdata (edge_q)
    );

    assign ea = edge_q[EW-1 -: VW];
    assign eb = edge_q[WEIGHT_BITS+VW-1 -: VW];
    assign ew = edge_q[WEIGHT_BITS-1:0];

    assign src_ok   = {1'b0, r_src} < vc_ext;
    assign src_addr = r_src[VW-1:0];

    assign cand = da + {{(DW-WEIGHT_BITS){ew[WEIGHT_BITS-1]}}, ew};
    assign upd  = r_reached[ea] && (!r_reached[eb] || (cand < db));

    assign dist_we    = (i_cmd.init_run && src_ok) || (i_cmd.relax && upd);
    assign dist_waddr = i_cmd.init_run ? src_addr : eb;
    assign dist_wdata = i_cmd.init_run ? '0 : cand;
    assign a_raddr    = i_cmd.out_rd ? r_vidx : ea;

    // a copy per read port, both written together
    bfsp_ram #(.W(DW), .D(MAX_VERTICES)) u_dist_a (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_re    (i_cmd.dist_rd || i_cmd.out_rd),
        .i_raddr (a_raddr),
        .o_rdata (da)
    );

    bfsp_ram #(.W(DW), .D(MAX_VERTICES)) u_dist_b (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_re    (i_cmd.dist_rd),
        .i_raddr (eb),
        .o_rdata (db)
    );

    assign vidx_last = (VCW'(r_vidx) + VCW'(1)) == r_vtx_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src        <= '0;
            r_edge_count <= '0;
            r_vtx_count  <= '0;
            r_eidx       <= '0;
            r_pass       <= '0;
            r_changed    <= 1'b0;
            r_vidx       <= '0;
            r_reached    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_src <= i_cfg_data;
            end
            if (i_cmd.clear_set) begin
                r_edge_count <= '0;
                r_vtx_count  <= '0;
            end else if (i_cmd.load_edge && store_ok) begin
                r_edge_count <= r_edge_count + ECW'(1);
                r_vtx_count  <= VCW'(n_vc_ext);
            end
            if (i_cmd.eidx_clr) begin
                r_eidx <= '0;
            end else if (i_cmd.eidx_inc) begin
                r_eidx <= r_eidx + ECW'(1);
            end
            if (i_cmd.pass_clr) begin
                r_pass <= '0;
            end else if (i_cmd.pass_inc) begin
                r_pass <= r_pass + VCW'(1);
            end
            if (i_cmd.clear_changed) begin
                r_changed <= 1'b0;
            end else if (i_cmd.relax && upd) begin
                r_changed <= 1'b1;
            end
            if (i_cmd.vidx_clr) begin
                r_vidx <= '0;
            end else if (i_cmd.vidx_inc) begin
                r_vidx <= r_vidx + VW'(1);
            end
            if (i_cmd.init_run) begin
                r_reached <= src_ok ? (MAX_VERTICES'(1) << src_addr) : '0;
            end else if (i_cmd.relax && upd) begin
                r_reached[eb] <= 1'b1;
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load_vtx) begin
            r_o_vertex <= VTX_BITS'(r_vidx);
            r_o_dist   <= r_reached[r_vidx] ? da[DIST_BITS-1:0] : DIST_INF;
            r_o_reach  <= r_reached[r_vidx];
            r_o_neg    <= 1'b0;
            r_o_last   <= vidx_last;
        end else if (i_cmd.out_load_neg) begin
            r_o_vertex <= '0;
            r_o_dist   <= '0;
            r_o_reach  <= 1'b0;
            r_o_neg    <= 1'b1;
            r_o_last   <= 1'b1;
        end
    end

    assign o_sts.empty    = (r_edge_count == '0);
    assign o_sts.edge_end = (r_eidx + ECW'(1)) == r_edge_count;
    assign o_sts.pass_end = (r_pass + VCW'(1)) == r_vtx_count;
    assign o_sts.changed  = r_changed;
    assign o_sts.out_last = r_o_last;

    assign o_vertex_index   = r_o_vertex;
    assign o_distance       = r_o_dist;
    assign o_reachable      = r_o_reach;
    assign o_negative_cycle = r_o_neg;
    assign o_result_last    = r_o_last;
endmodule

// ===== rtl/bellman_ford_shortest_paths_unit.sv =====
// loading: one edge word per cycle while idle; the last edge leads through start and init to the run
// run: per edge per pass an edge read, a distance read and a relax step, plus a pass check per pass
// output: per vertex a read, a load and a wait for the sink; a cycle result is loaded, then waits
// reset: synchronous active low, clears counts, reach flags and source (0)
// top level: ties controller and datapath, cfg port for source vertex
// depends on bfsp_pkg, bfsp_ctrl, bfsp_dpath
module bellman_ford_shortest_paths_unit #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [bfsp_pkg::VTX_BITS-1:0]         i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [bfsp_pkg::VTX_BITS-1:0]         i_edge_from,
    input  logic [bfsp_pkg::VTX_BITS-1:0]         i_edge_to,
    input  logic signed [WEIGHT_BITS-1:0]         i_edge_weight,
    input  logic                                  i_edge_last,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [bfsp_pkg::VTX_BITS-1:0]         o_vertex_index,
    output logic signed [bfsp_pkg::DIST_BITS-1:0] o_distance,
    output logic                                  o_reachable,
    output logic                                  o_negative_cycle,
    output logic                                  o_result_last
);
    import bfsp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    bfsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_edge_last (i_edge_last),
        .i_ready     (i_ready),
        .o_ready     (o_ready),
        .o_valid     (o_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bfsp_dpath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_edge_from      (i_edge_from),
        .i_edge_to        (i_edge_to),
        .i_edge_weight    (i_edge_weight),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_vertex_index   (o_vertex_index),
        .o_distance       (o_distance),
        .o_reachable      (o_reachable),
        .o_negative_cycle (o_negative_cycle),
        .o_result_last    (o_result_last)
    );

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input taken while a result is shown");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_result_last) |=> !o_valid)
        else $error("result after the final word");

    a_neg_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_negative_cycle) |-> (o_result_last && !o_reachable))
        else $error("bad cycle result word");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load_edge, cmd.init_run, cmd.relax, cmd.out_rd}))
        else $error("conflicting datapath commands");
`endif
endmodule

// ===== tb/sv/tb_bellman_ford_shortest_paths_unit.sv =====
// testbench for the shortest path unit: loads random and directed edge sets,
// predicts per-vertex distances or a negative cycle flag and checks each result word
// depends on bfsp_pkg and bellman_ford_shortest_paths_unit
module tb_bellman_ford_shortest_paths_unit;
    import bfsp_pkg::*;

    localparam int NV = 64;
    localparam int NE = 1024;
    localparam int WATCHDOG_LIMIT = 400000;

    typedef struct {
        logic [VTX_BITS-1:0]  vtx;
        logic signed [31:0]   dval;
        logic                 reach;
        logic                 neg;
        logic                 last;
    } t_res;

    logic i_clk, i_rst_n;
    logic i_cfg_valid;
    logic [VTX_BITS-1:0] i_cfg_data;
    logic i_valid, i_ready, i_edge_last;
    logic [VTX_BITS-1:0] i_edge_from, i_edge_to;
    logic signed [15:0] i_edge_weight;
    logic o_cfg_ready, o_ready, o_valid, o_reachable, o_negative_cycle, o_result_last;
    logic [VTX_BITS-1:0] o_vertex_index;
    logic signed [31:0] o_distance;

    bellman_ford_shortest_paths_unit dut (.*);

    // predictor state
    logic [VTX_BITS-1:0] src_vtx;
    logic [VTX_BITS-1:0] e_tail [NE];
    logic [VTX_BITS-1:0] e_head [NE];
    logic signed [15:0]  e_wt [NE];
    int n_edges, n_vtx;
    t_res pending_results [$];

    int mismatches, idle_cycles;
    bit sink_hold, quiet_mode, done;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic solve_set();
        longint d_tab [NV];
        bit     reach [NV];
        bit     changed, neg;
        longint cand;
        t_res   r;
        neg = 0;
        for (int v = 0; v < NV; v++) begin
            d_tab[v] = DIST_INF;
            reach[v] = 0;
        end
        if (src_vtx < n_vtx) begin
            d_tab[src_vtx] = 0;
            reach[src_vtx] = 1;
        end
        for (int p = 0; p < n_vtx; p++) begin
            changed = 0;
            for (int e = 0; e < n_edges; e++) begin
                if (reach[e_tail[e]]) begin
                    cand = d_tab[e_tail[e]] + e_wt[e];
                    if (!reach[e_head[e]] || cand < d_tab[e_head[e]]) begin
                        d_tab[e_head[e]] = cand;
                        reach[e_head[e]] = 1;
                        changed = 1;
                    end
                end
            end
            if (!changed) break;
            if (p == n_vtx - 1) neg = 1;
        end
        if (neg) begin
            r = '{0, 0, 0, 1, 1};
            pending_results.push_back(r);
        end else begin
            for (int v = 0; v < n_vtx; v++) begin
                r = '{v[5:0], d_tab[v][31:0], reach[v], 0, v == n_vtx - 1};
                pending_results.push_back(r);
            end
        end
    endtask

    task automatic predict_edge(logic [5:0] a, logic [5:0] b, logic signed [15:0] w,
                                logic last);
        if (n_edges < NE) begin
            e_tail[n_edges] = a;
            e_head[n_edges] = b;
            e_wt[n_edges] = w;
            n_edges++;
            if (a + 1 > n_vtx) n_vtx = a + 1;
            if (b + 1 > n_vtx) n_vtx = b + 1;
        end
        if (last) begin
            if (n_edges > 0) solve_set();
            n_edges = 0;
            n_vtx = 0;
        end
    endtask

    task automatic send_edge(logic [5:0] a, logic [5:0] b, logic signed [15:0] w,
                             logic last);
        int gap;
        if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_edge_from <= a;
        i_edge_to <= b;
        i_edge_weight <= w;
        i_edge_last <= last;
        do @(posedge i_clk); while (!o_ready);
        predict_edge(a, b, w, last);
    endtask

    task automatic wait_drained();
        i_valid <= 0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_source(logic [5:0] v);
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        src_vtx = v;
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        // single self loop, positive
        send_edge(0, 0, 5, 1);
        // chain with extreme weights
        send_edge(0, 1, 16'sh7fff, 0);
        send_edge(1, 2, 16'sh8000, 0);
        send_edge(2, 63, -1, 0);
        send_edge(63, 3, 0, 1);
        // negative cycle
        send_edge(0, 1, 2, 0);
        send_edge(1, 2, -3, 0);
        send_edge(2, 1, 0, 1);
        // duplicate edges and unreachable vertex
        send_edge(0, 4, 10, 0);
        send_edge(0, 4, 7, 0);
        send_edge(5, 0, 1, 1);
        // no set is empty: a lone last edge counts as an edge; here a negative self loop
        send_edge(0, 0, -1, 1);
        wait_drained();
        repeat (60) @(posedge i_clk);
        // source out of range
        write_source(63);
        send_edge(0, 1, 1, 0);
        send_edge(1, 2, 1, 1);
        wait_drained();
        repeat (60) @(posedge i_clk);
        write_source(2);
        send_edge(2, 0, 21845, 0);
        send_edge(0, 42, -21846, 1);
        wait_drained();
        repeat (60) @(posedge i_clk);
        write_source(0);
    endtask

    task automatic send_random_set(int n_max, int v_max, bit allow_neg);
        int n;
        logic signed [15:0] w;
        n = $urandom_range(1, n_max);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) w = $urandom;
            else if (allow_neg) w = $urandom_range(0, 200) - 40;
            else w = $urandom_range(0, 1000);
            send_edge($urandom_range(0, v_max), $urandom_range(0, v_max), w, i == n - 1);
        end
    endtask

    task automatic test_random();
        for (int s = 0; s < 72; s++) begin
            send_random_set(10, 9, s % 3 == 0);
            if (s % 15 == 14) begin
                wait_drained();
                repeat (60) @(posedge i_clk);
                write_source($urandom_range(0, 9));
            end
        end
        wait_drained();
        repeat (60) @(posedge i_clk);
        write_source(0);
        // a couple of wide sets
        send_random_set(25, 63, 0);
        send_random_set(25, 63, 1);
    endtask

    task automatic test_backpressure();
        sink_hold = 1;
        send_random_set(6, 5, 0);
        send_random_set(6, 5, 0);
        send_random_set(6, 5, 0);
        wait_drained();
    endtask

    task automatic test_no_idle();
        quiet_mode = 1;
        for (int s = 0; s < 10; s++) send_random_set(8, 7, 1);
    endtask

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (sink_hold) begin
            repeat (300) @(posedge i_clk);
            sink_hold <= 0;
        end
    end

    // sink ready
    initial begin
        int gap;
        i_ready = 0;
        @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (sink_hold) i_ready <= 0;
            else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 17);
                i_ready <= 0;
                repeat (gap) @(posedge i_clk);
                i_ready <= 1;
            end else i_ready <= 1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word vtx=%0d dist=%0d", o_vertex_index,
                             o_distance);
            end else begin
                e = pending_results.pop_front();
                if (o_vertex_index !== e.vtx || o_distance !== e.dval ||
                    o_reachable !== e.reach || o_negative_cycle !== e.neg ||
                    o_result_last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp v=%0d d=%0d r=%0b n=%0b l=%0b got %0d %0d %0b %0b %0b",
                                 e.vtx, e.dval, e.reach, e.neg, e.last, o_vertex_index,
                                 o_distance, o_reachable, o_negative_cycle, o_result_last);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)
            || done)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int guard;
        i_rst_n = 0;
        i_valid = 0;
        i_cfg_valid = 0;
        i_cfg_data = 0;
        i_edge_from = 0;
        i_edge_to = 0;
        i_edge_weight = 0;
        i_edge_last = 0;
        src_vtx = 0;
        n_edges = 0;
        n_vtx = 0;
        mismatches = 0;
        idle_cycles = 0;
        sink_hold = 0;
        quiet_mode = 0;
        done = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        test_no_idle();
        wait_drained();
        done = 1;
        guard = 0;
        while (guard < 2000 && !o_valid) begin
            @(posedge i_clk);
            guard++;
        end
        if (mismatches == 0 && pending_results.size() == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== bellman_ford_shortest_paths_unit.f =====
rtl/bfsp_pkg.sv
rtl/bfsp_ram.sv
rtl/bfsp_ctrl.sv
rtl/bfsp_dpath.sv
rtl/bellman_ford_shortest_paths_unit.sv
tb/sv/tb_bellman_ford_shortest_paths_unit.sv
